FILE: src/bptc_pkg.sv
// Package for the barometric pressure / temperature compensation pipeline.
// Holds field widths, stage count, register indexes and the temperature band codes.
// Used by baro_pressure_temp_compensation; depends on nothing.
package bptc_pkg;

    // interface field widths
    localparam int RAW_W    = 24;   // raw pressure and raw temperature words
    localparam int CAL_W    = 16;   // calibration words
    localparam int TOUT_W   = 18;   // compensated temperature
    localparam int POUT_W   = 32;   // compensated pressure
    localparam int BAND_W   = 2;
    localparam int CFG_IDX_W = 3;

    localparam int S_TDATA_W = 2 * RAW_W;
    localparam int M_TDATA_W = ((TOUT_W + POUT_W + BAND_W + 7) / 8) * 8;

    // datapath widths
    localparam int DT_W   = RAW_W + 1;          // D2 - C5*2^8
    localparam int LIN_W  = DT_W + CAL_W + 1;   // dT times a calibration word
    localparam int DD_W   = 2 * RAW_W;          // dT squared, never negative
    localparam int TEMP_W = 20;                 // first-order temperature
    localparam int T2_W   = DD_W - 31;          // dT^2 / 2^31
    localparam int SQ_W   = 35;                 // squares of the temperature offsets
    localparam int CORR_W = SQ_W + 4;           // OFF2 and SENS2
    localparam int ACC_W  = 40;                 // OFF and SENS
    localparam int SPLIT  = 20;                 // low slice of SENS for the split product
    localparam int PL_W   = RAW_W + SPLIT;
    localparam int PH_W   = RAW_W + 1 + ACC_W - SPLIT;
    localparam int PROD_W = 64;
    localparam int R_W    = 44;

    localparam int NSTG   = 9;                  // register stages, input to output

    localparam int TEMP_REF      = 2000;
    localparam int TEMP_VERY_LOW = -1500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS_BASE     = 3'd0,
        CFG_OFFSET_BASE   = 3'd1,
        CFG_SENS_TEMPCO   = 3'd2,
        CFG_OFFSET_TEMPCO = 3'd3,
        CFG_REF_TEMP      = 3'd4,
        CFG_TEMP_SLOPE    = 3'd5
    } cfg_reg_t;

    typedef enum logic [BAND_W-1:0] {
        BAND_NORMAL   = 2'd0,
        BAND_LOW      = 2'd1,
        BAND_VERY_LOW = 2'd2
    } temp_band_t;

endpackage

FILE: src/baro_pressure_temp_compensation.sv
// Second-order temperature compensation of barometric pressure, as a 9-stage pipeline.
// Depends on bptc_pkg for widths, register indexes and band codes.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+------------------------------------------------
//  s_      | in  | s_tvalid / s_tready     | s_tdata: raw_pressure, raw_temperature
//  m_      | out | m_tvalid / m_tready     | m_tdata: temp_centi_deg, pressure_centi_mbar,
//          |     |                         |          temp_band
//  cfg_    | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data (cfg_ready is always high)
//
// One beat per cycle is sustained while m_tready stays high.
// Each stage holds at most one multiplier row or one wide add; the D1*SENS product is
// split over two stages. Every stage advances when it is empty or its successor advances,
// so bubbles collapse and a stalled m_ side fills the pipe before s_tready drops.
// Reset clears the valid bits and the calibration words.
module baro_pressure_temp_compensation
    import bptc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [17:0] temp_centi_deg,
                                             // [49:18] pressure_centi_mbar,
                                             // [51:50] temp_band, [55:52] zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CAL_W-1:0]      cfg_data
);

    // ---------------- calibration registers ----------------
    logic [CAL_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
            c6_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SENS_BASE:     c1_reg <= cfg_data;
                CFG_OFFSET_BASE:   c2_reg <= cfg_data;
                CFG_SENS_TEMPCO:   c3_reg <= cfg_data;
                CFG_OFFSET_TEMPCO: c4_reg <= cfg_data;
                CFG_REF_TEMP:      c5_reg <= cfg_data;
                CFG_TEMP_SLOPE:    c6_reg <= cfg_data;
                default: ;         // drop writes beyond the register list
            endcase
        end
    end

    // ---------------- stage valids and advance chain ----------------
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] v_next;
    logic [NSTG-1:0] adv;

    always_comb begin
        adv[NSTG-1] = !v_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
        v_next[0] = s_tvalid;
        for (int k = 1; k < NSTG; k++) begin
            v_next[k] = v_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (adv[k]) begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = v_reg[NSTG-1];

    // ---------------- stage 0: dT ----------------
    logic        [RAW_W-1:0] d1_0_reg;
    logic signed [DT_W-1:0]  dt_reg, dt_next;

    assign dt_next = $signed({1'b0, s_tdata[S_TDATA_W-1:RAW_W]})
                   - $signed({1'b0, c5_reg, 8'd0});

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            d1_0_reg <= s_tdata[RAW_W-1:0];
            dt_reg   <= dt_next;
        end
    end

    // ---------------- stage 1: linear products and dT^2 ----------------
    logic        [RAW_W-1:0] d1_1_reg;
    logic signed [LIN_W-1:0] pt_reg, pt_next, po_reg, po_next, ps_reg, ps_next;
    logic signed [2*DT_W-1:0] dd_full;
    logic        [DD_W-1:0]  dd_reg, dd_next;

    assign pt_next = dt_reg * $signed({1'b0, c6_reg});
    assign po_next = dt_reg * $signed({1'b0, c4_reg});
    assign ps_next = dt_reg * $signed({1'b0, c3_reg});
    assign dd_full = dt_reg * dt_reg;
    assign dd_next = dd_full[DD_W-1:0];     // |dT| < 2^24, so the square fits

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            d1_1_reg <= d1_0_reg;
            pt_reg   <= pt_next;
            po_reg   <= po_next;
            ps_reg   <= ps_next;
            dd_reg   <= dd_next;
        end
    end

    // ---------------- stage 2: TEMP, OFF, SENS, T2 ----------------
    logic        [RAW_W-1:0]  d1_2_reg;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    logic signed [ACC_W-1:0]  off_2_reg, off_next, sens_2_reg, sens_next;
    logic        [T2_W-1:0]   t2_reg, t2_next;

    assign temp_next = TEMP_W'(pt_reg >>> 23) + TEMP_W'(TEMP_REF);
    assign off_next  = $signed({{(ACC_W-CAL_W-16){1'b0}}, c2_reg, 16'd0})
                     + ACC_W'(po_reg >>> 7);
    assign sens_next = $signed({{(ACC_W-CAL_W-15){1'b0}}, c1_reg, 15'd0})
                     + ACC_W'(ps_reg >>> 8);
    assign t2_next   = dd_reg[DD_W-1:31];

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            d1_2_reg   <= d1_1_reg;
            temp_reg   <= temp_next;
            off_2_reg  <= off_next;
            sens_2_reg <= sens_next;
            t2_reg     <= t2_next;
        end
    end

    // ---------------- stage 3: band, squares, output temperature ----------------
    logic        [RAW_W-1:0]   d1_3_reg;
    logic signed [ACC_W-1:0]   off_3_reg, sens_3_reg;
    logic signed [TEMP_W-1:0]  x_low, y_low;
    logic signed [2*TEMP_W-1:0] x_sq, y_sq;
    logic        [SQ_W-1:0]    xx_reg, xx_next, yy_reg, yy_next;
    temp_band_t                band_3_reg, band_next;
    logic signed [TEMP_W:0]    tdiff;
    logic        [TOUT_W-1:0]  tout_3_reg, tout_next;

    assign x_low = temp_reg - TEMP_W'(TEMP_REF);
    assign y_low = temp_reg - TEMP_W'(TEMP_VERY_LOW);
    assign x_sq  = x_low * x_low;
    assign y_sq  = y_low * y_low;
    assign xx_next = x_sq[SQ_W-1:0];    // |x| <= 2^17 wherever the square is used
    assign yy_next = y_sq[SQ_W-1:0];

    always_comb begin
        if (temp_reg < TEMP_W'(TEMP_VERY_LOW)) begin
            band_next = BAND_VERY_LOW;
        end else if (temp_reg < TEMP_W'(TEMP_REF)) begin
            band_next = BAND_LOW;
        end else begin
            band_next = BAND_NORMAL;
        end

        // T2 only applies below the reference temperature
        if (band_next == BAND_NORMAL) begin
            tdiff = (TEMP_W+1)'(temp_reg);
        end else begin
            tdiff = (TEMP_W+1)'(temp_reg) - $signed({{(TEMP_W+1-T2_W){1'b0}}, t2_reg});
        end

        // saturate to the output range
        if (tdiff[TEMP_W:TOUT_W-1] == '0 || tdiff[TEMP_W:TOUT_W-1] == '1) begin
            tout_next = tdiff[TOUT_W-1:0];
        end else if (tdiff[TEMP_W]) begin
            tout_next = {1'b1, {(TOUT_W-1){1'b0}}};
        end else begin
            tout_next = {1'b0, {(TOUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            d1_3_reg   <= d1_2_reg;
            off_3_reg  <= off_2_reg;
            sens_3_reg <= sens_2_reg;
            xx_reg     <= xx_next;
            yy_reg     <= yy_next;
            band_3_reg <= band_next;
            tout_3_reg <= tout_next;
        end
    end

    // ---------------- stage 4: OFF2, SENS2 ----------------
    logic        [RAW_W-1:0]  d1_4_reg;
    logic signed [ACC_W-1:0]  off_4_reg, sens_4_reg;
    logic        [CORR_W-1:0] x5, y7, y11;
    logic        [CORR_W-1:0] off2_reg, off2_next, sens2_reg, sens2_next;
    temp_band_t               band_4_reg;
    logic        [TOUT_W-1:0] tout_4_reg;

    assign x5  = CORR_W'({xx_reg, 2'b00}) + CORR_W'(xx_reg);
    assign y7  = CORR_W'({yy_reg, 3'b000}) - CORR_W'(yy_reg);
    assign y11 = CORR_W'({yy_reg, 3'b000}) + CORR_W'({yy_reg, 1'b0}) + CORR_W'(yy_reg);

    always_comb begin
        case (band_3_reg)
            BAND_LOW: begin
                off2_next  = x5 >> 1;
                sens2_next = x5 >> 2;
            end
            BAND_VERY_LOW: begin
                off2_next  = (x5 >> 1) + y7;
                sens2_next = (x5 >> 2) + (y11 >> 1);
            end
            default: begin
                off2_next  = '0;
                sens2_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv[4]) begin
            d1_4_reg   <= d1_3_reg;
            off_4_reg  <= off_3_reg;
            sens_4_reg <= sens_3_reg;
            off2_reg   <= off2_next;
            sens2_reg  <= sens2_next;
            band_4_reg <= band_3_reg;
            tout_4_reg <= tout_3_reg;
        end
    end

    // ---------------- stage 5: corrected OFF and SENS ----------------
    logic        [RAW_W-1:0]  d1_5_reg;
    logic signed [ACC_W-1:0]  offc_5_reg, offc_next, sensc_reg, sensc_next;
    temp_band_t               band_5_reg;
    logic        [TOUT_W-1:0] tout_5_reg;

    assign offc_next  = off_4_reg  - $signed({{(ACC_W-CORR_W){1'b0}}, off2_reg});
    assign sensc_next = sens_4_reg - $signed({{(ACC_W-CORR_W){1'b0}}, sens2_reg});

    always_ff @(posedge aclk) begin
        if (adv[5]) begin
            d1_5_reg   <= d1_4_reg;
            offc_5_reg <= offc_next;
            sensc_reg  <= sensc_next;
            band_5_reg <= band_4_reg;
            tout_5_reg <= tout_4_reg;
        end
    end

    // ---------------- stage 6: D1 * SENS as two partial products ----------------
    logic        [PL_W-1:0]   pl_reg, pl_next;
    logic signed [PH_W-1:0]   ph_reg, ph_next;
    logic signed [ACC_W-1:0]  offc_6_reg;
    temp_band_t               band_6_reg;
    logic        [TOUT_W-1:0] tout_6_reg;

    assign pl_next = PL_W'(d1_5_reg) * PL_W'(sensc_reg[SPLIT-1:0]);
    assign ph_next = $signed({1'b0, d1_5_reg}) * $signed(sensc_reg[ACC_W-1:SPLIT]);

    always_ff @(posedge aclk) begin
        if (adv[6]) begin
            pl_reg     <= pl_next;
            ph_reg     <= ph_next;
            offc_6_reg <= offc_5_reg;
            band_6_reg <= band_5_reg;
            tout_6_reg <= tout_5_reg;
        end
    end

    // ---------------- stage 7: combine partial products ----------------
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  offc_7_reg;
    temp_band_t               band_7_reg;
    logic        [TOUT_W-1:0] tout_7_reg;

    assign prod_next = (PROD_W'(ph_reg) <<< SPLIT) + $signed(PROD_W'(pl_reg));

    always_ff @(posedge aclk) begin
        if (adv[7]) begin
            prod_reg   <= prod_next;
            offc_7_reg <= offc_6_reg;
            band_7_reg <= band_6_reg;
            tout_7_reg <= tout_6_reg;
        end
    end

    // ---------------- stage 8: pressure, output register ----------------
    logic signed [R_W-1:0]    r_diff;
    logic        [POUT_W-1:0] pout_reg, pout_next;
    temp_band_t               band_8_reg;
    logic        [TOUT_W-1:0] tout_8_reg;

    assign r_diff = R_W'(prod_reg >>> 21) - R_W'(offc_7_reg);
    // with 24-bit D1 the result spans at most 29 bits, so truncating it to 32 bits loses nothing
    assign pout_next = POUT_W'(r_diff >>> 15);

    always_ff @(posedge aclk) begin
        if (adv[8]) begin
            pout_reg   <= pout_next;
            band_8_reg <= band_7_reg;
            tout_8_reg <= tout_7_reg;
        end
    end

    assign m_tdata = {{(M_TDATA_W-TOUT_W-POUT_W-BAND_W){1'b0}},
                      band_8_reg, pout_reg, tout_8_reg};

    // ---------------- assertions ----------------
    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_full_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (&v_reg) && !m_tready |-> !s_tready)
        else $error("input accepted while every stage is full and the output is stalled");

    a_normal_band_temp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && band_8_reg == BAND_NORMAL |-> $signed(tout_8_reg) >= TOUT_W'(TEMP_REF))
        else $error("normal band with temperature below the reference");

    a_low_band_temp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (band_8_reg == BAND_LOW || band_8_reg == BAND_VERY_LOW)
        |-> $signed(tout_8_reg) < TOUT_W'(TEMP_REF))
        else $error("low band with temperature at or above the reference");

    a_stage_moves_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[NSTG-2] && adv[NSTG-1] |=> m_tvalid)
        else $error("valid result lost between the last two stages");

endmodule

FILE: tb/sv/bptc_compensation_checker.sv
`timescale 1ns / 100ps
// Result checker for the pressure / temperature compensation pipeline: tracks the
// calibration words, predicts each reading and compares it with the m_ side beats.
// Depends on bptc_pkg for widths, register indexes and band codes.
module bptc_compensation_checker
    import bptc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CAL_W-1:0]      cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    checked,
    output int                    low_hits,
    output int                    very_low_hits
);

    localparam longint TOUT_MAX = (longint'(1) << (TOUT_W - 1)) - 1;
    localparam longint TOUT_MIN = -(longint'(1) << (TOUT_W - 1));
    localparam longint POUT_MAX = (longint'(1) << (POUT_W - 1)) - 1;
    localparam longint POUT_MIN = -(longint'(1) << (POUT_W - 1));

    typedef struct packed {
        logic signed [TOUT_W-1:0] temp;
        logic signed [POUT_W-1:0] press;
        temp_band_t               band;
    } reading_t;

    logic [CAL_W-1:0] cal_words [int'(CFG_TEMP_SLOPE) + 1];
    reading_t         expected_readings [$];

    function automatic reading_t compensate(input logic [RAW_W-1:0] d1,
                                            input logic [RAW_W-1:0] d2);
        longint   dt, t1, off, sens, t2, off2, sens2, sq, tc, p;
        reading_t r;
        dt   = longint'(d2) - (longint'(cal_words[CFG_REF_TEMP]) <<< 8);
        t1   = TEMP_REF + ((dt * longint'(cal_words[CFG_TEMP_SLOPE])) >>> 23);
        off  = (longint'(cal_words[CFG_OFFSET_BASE]) <<< 16)
             + ((longint'(cal_words[CFG_OFFSET_TEMPCO]) * dt) >>> 7);
        sens = (longint'(cal_words[CFG_SENS_BASE]) <<< 15)
             + ((longint'(cal_words[CFG_SENS_TEMPCO]) * dt) >>> 8);
        t2     = 0;
        off2   = 0;
        sens2  = 0;
        r.band = BAND_NORMAL;
        if (t1 < TEMP_REF) begin
            sq     = (t1 - TEMP_REF) * (t1 - TEMP_REF);
            r.band = BAND_LOW;
            t2     = (dt * dt) >>> 31;
            off2   = (5 * sq) >>> 1;
            sens2  = (5 * sq) >>> 2;
            if (t1 < TEMP_VERY_LOW) begin
                sq     = (t1 - TEMP_VERY_LOW) * (t1 - TEMP_VERY_LOW);
                r.band = BAND_VERY_LOW;
                off2   = off2 + 7 * sq;
                sens2  = sens2 + ((11 * sq) >>> 1);
            end
        end
        // band and pressure terms use the unclamped first-order temperature
        tc = t1 - t2;
        if (tc > TOUT_MAX) tc = TOUT_MAX;
        if (tc < TOUT_MIN) tc = TOUT_MIN;
        off  = off - off2;
        sens = sens - sens2;
        p = (((longint'(d1) * sens) >>> 21) - off) >>> 15;
        if (p > POUT_MAX) p = POUT_MAX;
        if (p < POUT_MIN) p = POUT_MIN;
        r.temp  = tc[TOUT_W-1:0];
        r.press = p[POUT_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        fail_count++;
        $display("%0t ns: mismatch: %s", $time, what);
    endtask

    always @(posedge aclk) begin : watch
        reading_t want;
        reading_t got;
        if (!aresetn) begin
            expected_readings.delete();
            foreach (cal_words[i]) cal_words[i] = '0;
            pending <= 0;
        end else begin
            // indexes past the last register are dropped by the block
            if (cfg_valid && cfg_ready && cfg_index <= CFG_TEMP_SLOPE)
                cal_words[cfg_index] = cfg_data;
            if (s_tvalid && s_tready)
                expected_readings.push_back(compensate(s_tdata[RAW_W-1:0],
                                                       s_tdata[S_TDATA_W-1:RAW_W]));
            if (m_tvalid && m_tready) begin
                got.temp  = m_tdata[TOUT_W-1:0];
                got.press = m_tdata[TOUT_W +: POUT_W];
                got.band  = temp_band_t'(m_tdata[TOUT_W + POUT_W +: BAND_W]);
                if (expected_readings.size() == 0) begin
                    flag_mismatch("result beat with no conversion outstanding");
                end else begin
                    want = expected_readings.pop_front();
                    checked++;
                    if (want.band == BAND_LOW) low_hits++;
                    if (want.band == BAND_VERY_LOW) very_low_hits++;
                    if (got.temp !== want.temp)
                        flag_mismatch($sformatf("temp_centi_deg %0d, expected %0d",
                                                got.temp, want.temp));
                    if (got.press !== want.press)
                        flag_mismatch($sformatf("pressure_centi_mbar %0d, expected %0d",
                                                got.press, want.press));
                    if (got.band !== want.band)
                        flag_mismatch($sformatf("temp_band %0d, expected %0d",
                                                got.band, want.band));
                end
            end
            pending <= expected_readings.size();
        end
    end

endmodule

FILE: tb/sv/baro_pressure_temp_compensation_tb.sv
`timescale 1ns / 100ps
// Testbench top for baro_pressure_temp_compensation: drives conversion pairs and
// calibration writes with random idling; bptc_compensation_checker does the checking.
// Depends on bptc_pkg, the block and the checker.
module baro_pressure_temp_compensation_tb
    import bptc_pkg::*;
();

    localparam logic [RAW_W-1:0] RAW_MAX    = '1;
    localparam int               NCAL        = int'(CFG_TEMP_SLOPE) + 1;
    localparam int               PHASES      = 8;
    localparam int               PHASE_ITEMS = 184;
    localparam int               CALM_PHASE  = 6;       // no idling from this phase on
    localparam int               HOLD_CYCLES = 80;
    localparam logic [RAW_W-1:0] D1_TYPICAL  = 24'd9085466;
    localparam longint           BAND_SPAN   = TEMP_REF - TEMP_VERY_LOW;
    localparam time              TIMEOUT_NS  = 10_000_000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CAL_W-1:0]     cfg_data  = '0;

    int fail_count, pending, checked, low_hits, very_low_hits;
    int n_sent     = 0;
    int n_cal_sets = 0;

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_req   = 1'b0;
    bit rx_holding = 1'b0;

    logic [CAL_W-1:0] cal_set [NCAL];

    always #10 aclk = ~aclk;

    baro_pressure_temp_compensation i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bptc_compensation_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked),
        .low_hits      (low_hits),
        .very_low_hits (very_low_hits)
    );

    function automatic longint raw_at_ref();
        return longint'(cal_set[CFG_REF_TEMP]) << 8;
    endfunction

    // lowest raw temperature that still gives at least -15.00 C first order
    function automatic longint very_low_edge();
        longint q;
        q = 0;
        if (cal_set[CFG_TEMP_SLOPE] != 0)
            q = (BAND_SPAN << 23) / longint'(cal_set[CFG_TEMP_SLOPE]);
        return raw_at_ref() - q;
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw_temp();
        longint v;
        case ($urandom_range(0, 9))
            0, 1:    v = raw_at_ref() + longint'($urandom_range(0, 8191)) - 4096;
            2, 3:    v = very_low_edge() + longint'($urandom_range(0, 63)) - 32;
            4:       v = $urandom_range(0, 1) ? longint'(RAW_MAX) : longint'(0);
            5:       v = longint'(1) << $urandom_range(0, RAW_W - 1);
            default: v = longint'($urandom_range(0, RAW_MAX));
        endcase
        if (v < 0) v = 0;
        if (v > longint'(RAW_MAX)) v = longint'(RAW_MAX);
        return RAW_W'(v);
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw_pressure();
        logic [RAW_W-1:0] d;
        case ($urandom_range(0, 9))
            0:       d = '0;
            1:       d = RAW_MAX;
            2:       d = RAW_W'(1) << $urandom_range(0, RAW_W - 1);
            default: d = RAW_W'($urandom_range(0, RAW_MAX));
        endcase
        return d;
    endfunction

    task automatic load_typical(input bit jitter);
        cal_set[CFG_SENS_BASE]     = 16'd40127;
        cal_set[CFG_OFFSET_BASE]   = 16'd36924;
        cal_set[CFG_SENS_TEMPCO]   = 16'd23317;
        cal_set[CFG_OFFSET_TEMPCO] = 16'd23282;
        cal_set[CFG_REF_TEMP]      = 16'd33464;
        cal_set[CFG_TEMP_SLOPE]    = 16'd28312;
        if (jitter)
            foreach (cal_set[i]) cal_set[i] = cal_set[i] ^ CAL_W'($urandom_range(0, 4095));
    endtask

    // hold cfg_valid across the whole burst; spare indexes must be ignored
    task automatic write_cal(input bit with_spare);
        for (int i = 0; i < (with_spare ? NCAL + 2 : NCAL); i++) begin
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= (i < NCAL) ? cal_set[i] : CAL_W'($urandom);
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        n_cal_sets++;
    endtask

    task automatic send_pair(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        if (tx_idle_en && !hold_req && !rx_holding && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tdata  <= {d2, d1};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        n_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    initial begin : result_sink
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req   = 1'b0;
                rx_holding = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                rx_holding = 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        longint edge_code;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // calibration still all zero after reset
        send_pair('0, '0);
        send_pair(RAW_MAX, RAW_MAX);
        drain();

        load_typical(1'b0);
        write_cal(1'b0);
        edge_code = very_low_edge();
        send_pair('0, '0);
        send_pair(RAW_MAX, RAW_MAX);
        send_pair('0, RAW_MAX);
        send_pair(RAW_MAX, '0);
        send_pair(D1_TYPICAL, RAW_W'(raw_at_ref()));
        send_pair(D1_TYPICAL, RAW_W'(raw_at_ref() - 1));
        send_pair(D1_TYPICAL, RAW_W'(edge_code));
        send_pair(D1_TYPICAL, RAW_W'(edge_code - 1));
        drain();

        // all-ones words: deep cold clamps the temperature at its low end
        foreach (cal_set[i]) cal_set[i] = '1;
        write_cal(1'b0);
        send_pair('0, '0);
        send_pair(RAW_MAX, RAW_MAX);
        send_pair(RAW_MAX, '0);
        send_pair('0, RAW_MAX);
        drain();

        // zero reference with steepest slope: clamps at the high end
        cal_set[CFG_REF_TEMP] = '0;
        write_cal(1'b1);
        send_pair(RAW_MAX, RAW_MAX);
        send_pair('0, RAW_MAX);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph % 2 == 0)
                load_typical(1'b1);
            else
                foreach (cal_set[i]) cal_set[i] = CAL_W'($urandom);
            write_cal(ph == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) begin
                    tx_idle_en = ph < CALM_PHASE && $urandom_range(0, 2) != 0;
                    rx_idle_en = ph < CALM_PHASE && $urandom_range(0, 2) != 0;
                end
                if (ph == 2 && n == 60) hold_req = 1'b1;
                if (ph == 4 && n == 90) drain();
                send_pair(pick_raw_pressure(), pick_raw_temp());
            end
            drain();
        end

        repeat (NSTG + 4) @(posedge aclk);
        $display("Ran %0d conversion pairs over %0d calibration sets, zero and all-ones included;",
                 n_sent, n_cal_sets);
        $display("%0d readings checked, %0d in the low band and %0d in the very low band.",
                 checked, low_hits, very_low_hits);
        if (fail_count == 0) begin
            $display("baro_pressure_temp_compensation_tb passed");
        end else begin
            $display("baro_pressure_temp_compensation_tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("Timed out with %0d readings outstanding", pending);
        $display("baro_pressure_temp_compensation_tb failed");
        $finish;
    end

endmodule
